>>> src/mrpt_pkg.sv
// Package for the Miller-Rabin primality tester: sequencer states and width constants.
// Has no dependencies of its own.
`default_nettype none
package mrpt_pkg;
	localparam int unsigned DataWidth = 64;
	localparam int unsigned OperandWidth = 64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_SPLIT,
		ST_POW_STEP,
		ST_MUL,
		ST_POW_NEXT,
		ST_CHECK,
		ST_SQUARE,
		ST_SQ_CHECK,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MUL_ACC,
		MUL_BASE,
		MUL_X
	} mul_dest_t;
endpackage
`default_nettype wire

>>> src/miller_rabin_primality_test.sv
// Miller-Rabin primality tester top level: sequencer and one shared shift-add modular unit.
// Depends on mrpt_pkg.
//
// A candidate and one witness arrive in each input transaction. The block takes
// no new transaction until that witness has been settled. Trivial candidates
// (at most 3, or even) go straight to the end. For odd n of 5 or more, the
// witness is first reduced modulo n by restoring subtraction. Then n-1 is
// split into d times 2^r at one bit a cycle. After that every modular
// multiplication passes through the single shift-add unit at one bit of the
// multiplier a cycle, with set-up and bookkeeping states around it. Together
// the exponentiation and the squarings need at most about 2*WIDTH
// multiplications. The verdicts of a group of witnesses are ANDed. A result
// transaction carries the group verdict and goes out only on the last witness
// of the group. It is held in an output register until it is taken. The next
// input transaction can be taken while the result waits. If that next witness
// is itself the last of its group, the block holds in its final state until
// the register is free.
`default_nettype none
module miller_rabin_primality_test #(
	parameter int unsigned WIDTH = mrpt_pkg::OperandWidth
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [mrpt_pkg::DataWidth-1:0]      candidate,
	input  wire logic [mrpt_pkg::DataWidth-1:0]      witness,
	input  wire logic                                last_witness,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     probable_prime
);
	import mrpt_pkg::*;

	localparam int unsigned CntW = $clog2(WIDTH + 1);

	state_t state_q, state_d;
	logic [WIDTH-1:0] n_q, a_q, d_q, acc_q, x_q, mx_q, my_q, macc_q, rem_q;
	logic [CntW-1:0] r_q, j_q, bit_q;
	mul_dest_t dest_q;
	logic last_q, all_passed_q, verdict_q;
	logic out_valid_q, prime_q;

	logic [WIDTH-1:0] n_in, a_in, nm1;
	logic trivial;
	assign n_in = candidate[WIDTH-1:0];
	assign a_in = witness[WIDTH-1:0];
	assign nm1  = n_q - WIDTH'(1);
	assign trivial = (n_in <= WIDTH'(3)) || !n_in[0];

	// Shared unit: one doubling plus a conditional addition, both modulo n.
	// The carry bit keeps the sums exact when n uses the top bit.
	logic [WIDTH:0] dbl, dbl_red, add1, add1_red;
	logic [WIDTH-1:0] dbl_m, mstep;
	assign dbl     = {macc_q, 1'b0};
	assign dbl_red = dbl - {1'b0, n_q};
	assign dbl_m   = (dbl >= {1'b0, n_q}) ? dbl_red[WIDTH-1:0] : dbl[WIDTH-1:0];
	assign add1    = {1'b0, dbl_m} + {1'b0, mx_q};
	assign add1_red = add1 - {1'b0, n_q};
	always_comb begin
		if (!my_q[WIDTH-1]) begin
			mstep = dbl_m;
		end else if (add1 >= {1'b0, n_q}) begin
			mstep = add1_red[WIDTH-1:0];
		end else begin
			mstep = add1[WIDTH-1:0];
		end
	end

	// Restoring reduction of the witness, also shift-subtract through the same kind of step.
	logic [WIDTH:0] rem_sh, rem_sub;
	assign rem_sh  = {rem_q, a_q[WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, n_q};

	logic accept;
	logic done_go;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	// A group verdict may only leave the final state once the output register is free.
	assign done_go  = !(last_q && out_valid_q && out_stall);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (trivial) state_d = ST_DONE;
					else state_d = ST_REDUCE;
				end
			end
			ST_REDUCE: if (bit_q == CntW'(WIDTH)) state_d = ST_SPLIT;
			ST_SPLIT: if (d_q[0]) state_d = ST_POW_STEP;
			ST_POW_STEP: begin
				if (d_q == '0) state_d = ST_CHECK;
				else state_d = ST_MUL;
			end
			ST_MUL: begin
				if (bit_q == CntW'(WIDTH)) begin
					case (dest_q)
						MUL_X: state_d = ST_SQ_CHECK;
						default: state_d = ST_POW_NEXT;
					endcase
				end
			end
			ST_POW_NEXT: state_d = ST_POW_STEP;
			ST_CHECK: begin
				if (acc_q == WIDTH'(1) || acc_q == nm1 || r_q <= CntW'(1)) state_d = ST_DONE;
				else state_d = ST_SQUARE;
			end
			ST_SQUARE: state_d = ST_MUL;
			ST_SQ_CHECK: begin
				if (x_q == nm1 || j_q + CntW'(1) >= r_q) state_d = ST_DONE;
				else state_d = ST_SQUARE;
			end
			ST_DONE: if (done_go) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			all_passed_q <= 1'b1;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (state_q == ST_DONE && done_go) begin
				if (last_q) begin
					out_valid_q  <= 1'b1;
					all_passed_q <= 1'b1;
				end else begin
					all_passed_q <= all_passed_q & verdict_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q     <= n_in;
				a_q     <= a_in;
				last_q  <= last_witness;
				rem_q   <= '0;
				bit_q   <= '0;
				r_q     <= '0;
				d_q     <= n_in - WIDTH'(1);
				acc_q   <= WIDTH'(1);
				// Trivial candidates are settled here and skip the arithmetic.
				if (n_in <= WIDTH'(1) || (!n_in[0] && n_in != WIDTH'(2))) begin
					verdict_q <= 1'b0;
				end else begin
					verdict_q <= 1'b1;
				end
			end
			ST_REDUCE: begin
				if (bit_q == CntW'(WIDTH)) begin
					x_q <= rem_q;
				end else begin
					rem_q <= (rem_sh >= {1'b0, n_q}) ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
					a_q   <= {a_q[WIDTH-2:0], 1'b0};
					bit_q <= bit_q + CntW'(1);
				end
			end
			ST_SPLIT: begin
				if (!d_q[0]) begin
					d_q <= d_q >> 1;
					r_q <= r_q + CntW'(1);
				end
			end
			ST_POW_STEP: begin
				if (d_q != '0) begin
					bit_q  <= '0;
					macc_q <= '0;
					if (d_q[0]) begin
						mx_q <= acc_q; my_q <= x_q; dest_q <= MUL_ACC;
					end else begin
						mx_q <= x_q; my_q <= x_q; dest_q <= MUL_BASE;
					end
				end
			end
			ST_MUL: begin
				if (bit_q == CntW'(WIDTH)) begin
					case (dest_q)
						MUL_ACC: acc_q <= macc_q;
						default: x_q <= macc_q;
					endcase
				end else begin
					macc_q <= mstep;
					my_q   <= {my_q[WIDTH-2:0], 1'b0};
					bit_q  <= bit_q + CntW'(1);
				end
			end
			ST_POW_NEXT: begin
				if (dest_q == MUL_ACC) begin
					// Square the base next; the exponent bit is consumed afterwards.
					bit_q <= '0; macc_q <= '0;
					mx_q <= x_q; my_q <= x_q; dest_q <= MUL_BASE;
					d_q[0] <= 1'b0;
				end else begin
					d_q <= d_q >> 1;
				end
			end
			ST_CHECK: begin
				x_q <= acc_q;
				j_q <= CntW'(1);
				if (acc_q == WIDTH'(1) || acc_q == nm1) verdict_q <= 1'b1;
				else verdict_q <= 1'b0;
			end
			ST_SQUARE: begin
				bit_q <= '0; macc_q <= '0;
				mx_q <= x_q; my_q <= x_q; dest_q <= MUL_X;
			end
			ST_SQ_CHECK: begin
				j_q <= j_q + CntW'(1);
				if (x_q == nm1) verdict_q <= 1'b1;
			end
			ST_DONE: begin
				if (last_q && done_go) prime_q <= all_passed_q & verdict_q;
			end
			default: ;
		endcase
	end

	// Trivial candidates go straight from idle to the final state.
	assign out_valid      = out_valid_q;
	assign probable_prime = prime_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !accept) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(prime_q)))
		else $error("result dropped under stall");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && done_go) |=> (state_q == ST_IDLE))
		else $error("done not followed by idle");
	a_mul_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (bit_q <= CntW'(WIDTH))) else $error("multiply counter overrun");
endmodule
`default_nettype wire

>>> sim/miller_rabin_primality_test_checker.sv
// Checker for the Miller-Rabin primality tester: watches both channels, predicts verdicts.
// Depends on mrpt_pkg for the data width; stands beside the block in the testbench top.
`timescale 1ns / 1ps
module miller_rabin_primality_test_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [mrpt_pkg::DataWidth-1:0]   candidate,
	input  logic [mrpt_pkg::DataWidth-1:0]   witness,
	input  logic                             last_witness,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             probable_prime,
	output int                               fail_count,
	output int                               verdicts_pending
);
	typedef logic [63:0] word_t;

	logic  group_ok;
	logic  verdict_queue[$];

	function automatic word_t sum_mod(word_t x, word_t y, word_t m);
		logic [64:0] s;
		s = {1'b0, x} + {1'b0, y};
		if (s >= {1'b0, m}) s = s - {1'b0, m};
		return s[63:0];
	endfunction

	// Double-width product, reduced exactly.
	function automatic word_t prod_mod(word_t x, word_t y, word_t m);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		return word_t'(p % {64'd0, m});
	endfunction

	function automatic word_t exp_mod(word_t b, word_t e, word_t m);
		word_t acc;
		acc = 64'd1;
		b = b % m;
		while (e != 0) begin
			if (e[0]) acc = prod_mod(acc, b, m);
			b = prod_mod(b, b, m);
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic logic base_passes(word_t n, word_t a);
		word_t d, x;
		int r;
		if (n <= 1) return 1'b0;
		if (n == 2 || n == 3) return 1'b1;
		if (!n[0]) return 1'b0;
		d = n - 1;
		r = 0;
		while (!d[0]) begin
			d = d >> 1;
			r++;
		end
		x = exp_mod(a, d, n);
		if (x == 1 || x == n - 1) return 1'b1;
		for (int j = 1; j < r; j++) begin
			x = prod_mod(x, x, n);
			if (x == n - 1) return 1'b1;
		end
		return 1'b0;
	endfunction

	assign verdicts_pending = verdict_queue.size();

	always @(posedge clk or negedge arst_n) begin
		logic want;
		logic acc;
		if (!arst_n) begin
			group_ok <= 1'b1;
			fail_count <= 0;
			verdict_queue.delete();
		end else begin
			if (in_valid && !in_stall) begin
				acc = group_ok & base_passes(candidate, witness);
				if (last_witness) begin
					verdict_queue.push_back(acc);
					group_ok <= 1'b1;
				end else begin
					group_ok <= acc;
				end
			end
			if (out_valid && !out_stall) begin
				if (verdict_queue.size() == 0) begin
					$error("probable_prime: no verdict expected, got %0b", probable_prime);
					fail_count <= fail_count + 1;
				end else begin
					want = verdict_queue.pop_front();
					if (probable_prime !== want) begin
						$error("probable_prime: expected %0b, got %0b", want, probable_prime);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

>>> sim/miller_rabin_primality_test_test.sv
// Testbench top for the Miller-Rabin primality tester: clock, reset, stimulus, verdict.
// Depends on mrpt_pkg, the block and miller_rabin_primality_test_checker.
`timescale 1ns / 1ps
module miller_rabin_primality_test_test;
	localparam int WatchdogLimit = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [63:0] candidate;
	logic [63:0] witness;
	logic        last_witness;
	logic        out_valid;
	logic        out_stall;
	logic        probable_prime;
	int          fail_count;
	int          verdicts_pending;
	logic        hold_off;
	int          idle_cycles;

	miller_rabin_primality_test u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.candidate(candidate), .witness(witness), .last_witness(last_witness),
		.out_valid(out_valid), .out_stall(out_stall), .probable_prime(probable_prime)
	);

	miller_rabin_primality_test_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.candidate(candidate), .witness(witness), .last_witness(last_witness),
		.out_valid(out_valid), .out_stall(out_stall), .probable_prime(probable_prime),
		.fail_count(fail_count), .verdicts_pending(verdicts_pending)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Primes and composites, strong pseudoprimes among them.
	logic [63:0] known_numbers[12] = '{
		64'd5, 64'd7, 64'd2047, 64'd3215031751, 64'd1000000007,
		64'd18446744073709551557, 64'd18446744073709551615, 64'd561,
		64'd9223372036854775783, 64'd4294967291, 64'd25326001, 64'd97
	};

	// Offers one transaction and holds it until it is taken.
	task automatic send_witness(input logic [63:0] n, input logic [63:0] a, input logic last);
		in_valid <= 1'b1;
		candidate <= n;
		witness <= a;
		last_witness <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		in_valid <= 1'b0;
		candidate <= {$urandom, $urandom};
		witness <= {$urandom, $urandom};
		repeat (cycles) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_base(logic [63:0] n);
		logic [63:0] r;
		if (n < 5) return {$urandom, $urandom};
		r = {$urandom, $urandom};
		return 64'd2 + r % (n - 64'd3);
	endfunction

	function automatic logic [63:0] pick_number();
		case ($urandom_range(0, 3))
			0: return known_numbers[$urandom_range(0, 11)];
			1: return {$urandom, $urandom} | 64'd1;
			2: return {32'd0, $urandom} | 64'd1;
			default: return 64'd5 + 2 * $urandom_range(0, 5000);
		endcase
	endfunction

	// Receiver: its own stall pattern, plus a long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_stall <= 1'b0;
		else out_stall <= hold_off || ($urandom_range(0, 3) == 0 && $urandom_range(0, 1));
	end

	initial begin
		hold_off = 1'b0;
		@(posedge arst_n);
		repeat (30) @(posedge clk);
		hold_off = 1'b1;
		repeat (60000) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) idle_cycles <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WatchdogLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		logic [63:0] n;
		int burst;
		int group;
		arst_n = 1'b0;
		in_valid = 1'b0;
		candidate = '0;
		witness = '0;
		last_witness = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Trivial candidates, wide and out-of-range witnesses, groups spanning several candidates.
		send_witness(64'd0, 64'd0, 1'b1);
		send_witness(64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		send_witness(64'd2, 64'd7, 1'b1);
		send_witness(64'd3, 64'd0, 1'b1);
		send_witness(64'd4, 64'd2, 1'b1);
		send_witness(64'hFFFF_FFFF_FFFF_FFFE, 64'd3, 1'b1);
		send_witness(64'd2047, 64'd2, 1'b0);
		send_witness(64'd2047, 64'd3, 1'b1);
		send_witness(64'd97, 64'd0, 1'b1);
		send_witness(64'd97, 64'd96, 1'b1);
		send_witness(64'd97, 64'd98, 1'b1);
		send_witness(64'd97, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		send_witness(64'd18446744073709551557, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0);
		send_witness(64'd18446744073709551615, 64'd2, 1'b1);
		send_witness(64'd561, 64'd2, 1'b0);
		send_witness(64'd3, 64'd1, 1'b0);
		send_witness(64'd5, 64'd1, 1'b1);
		send_witness(64'd3215031751, 64'd2, 1'b1);

		// Wait for every verdict before the random part.
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_pending != 0) @(posedge clk);

		for (int i = 0; i < 82; ) begin
			burst = $urandom_range(1, 6);
			for (int b = 0; b < burst && i < 82; b++) begin
				n = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} : pick_number();
				group = $urandom_range(1, 3);
				for (int g = 0; g < group; g++) begin
					if ($urandom_range(0, 9) == 0)
						send_witness(n, {$urandom, $urandom}, g == group - 1);
					else
						send_witness(n, pick_base(n), g == group - 1);
					i++;
				end
			end
			if ($urandom_range(0, 1)) pause_sender($urandom_range(1, 40));
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
